@@ design/fmvs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FM voice silence estimator package
// Shared types, codes and time tables for the silence-time pipeline.
// ----------------------------------------------------------------------------
package fmvs_pkg;

    localparam int TIME_BITS_DEF = 48;
    localparam int NUM_OPS       = 4;
    localparam int ENV_BITS      = 18;
    localparam int TAB_BITS      = 22;
    localparam int DUR_BITS      = 28;

    typedef enum logic [1:0] {
        OUTCOME_TIME    = 2'd0,
        OUTCOME_NEVER   = 2'd1,
        OUTCOME_SILENT  = 2'd2,
        OUTCOME_UNUSED  = 2'd3
    } outcome_t;

    typedef struct packed {
        logic       eval;
        logic       never;
        logic [4:0] lvl;
        logic [TAB_BITS-1:0] atk;
        logic [TAB_BITS-1:0] dec_step;
        logic [TAB_BITS-1:0] rel_step;
    } op_info_t;

    function automatic logic [5:0] scaled_rate(input logic [3:0] r, input logic [3:0] ksn);
        logic [6:0] v;
        begin
            v = {1'b0, r, 2'b00} + {3'b000, ksn};
            scaled_rate = (v > 7'd63) ? 6'd63 : v[5:0];
        end
    endfunction

    function automatic logic [TAB_BITS-1:0] atk_lookup(input logic [5:0] idx);
        logic [TAB_BITS-1:0] t [64];
        begin
            t = '{22'd0, 22'd0, 22'd0, 22'd0, 22'd2826240, 22'd2252800, 22'd1884160,
                22'd1597440, 22'd1413120, 22'd1126400, 22'd942080, 22'd798720,
                22'd706560, 22'd563200, 22'd471040, 22'd399360, 22'd353280,
                22'd281600, 22'd235520, 22'd199680, 22'd176760, 22'd140800,
                22'd117760, 22'd99840, 22'd88320, 22'd70400, 22'd58880, 22'd49920,
                22'd44160, 22'd35200, 22'd29440, 22'd24960, 22'd22080, 22'd17600,
                22'd14720, 22'd12480, 22'd11040, 22'd8800, 22'd7360, 22'd6240,
                22'd5520, 22'd4400, 22'd3680, 22'd3120, 22'd2760, 22'd2200,
                22'd1840, 22'd1560, 22'd1400, 22'd1120, 22'd920, 22'd800, 22'd700,
                22'd560, 22'd460, 22'd420, 22'd380, 22'd300, 22'd240, 22'd200,
                22'd0, 22'd0, 22'd0, 22'd0};
            atk_lookup = t[idx];
        end
    endfunction

    function automatic logic [TAB_BITS-1:0] rel_lookup(input logic [5:0] idx);
        logic [TAB_BITS-1:0] t [64];
        begin
            t = '{22'd0, 22'd0, 22'd0, 22'd0, 22'd1318207, 22'd1054566, 22'd878791,
                22'd749154, 22'd659104, 22'd527283, 22'd439396, 22'd374577,
                22'd329552, 22'd263641, 22'd219698, 22'd187288, 22'd164776,
                22'd131821, 22'd109849, 22'd93644, 22'd82388, 22'd65910, 22'd54924,
                22'd46822, 22'd41194, 22'd32955, 22'd27462, 22'd23411, 22'd20597,
                22'd16478, 22'd13731, 22'd11706, 22'd10298, 22'd8239, 22'd6866,
                22'd5853, 22'd5149, 22'd4119, 22'd3433, 22'd2926, 22'd2575,
                22'd2060, 22'd1716, 22'd1463, 22'd1287, 22'd1030, 22'd858, 22'd732,
                22'd644, 22'd515, 22'd429, 22'd366, 22'd322, 22'd257, 22'd215,
                22'd183, 22'd161, 22'd129, 22'd107, 22'd91, 22'd80, 22'd80, 22'd80,
                22'd80};
            rel_lookup = t[idx];
        end
    endfunction

endpackage

@@ design/fmvs_op_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FM voice silence estimator operator decode
// Unpacks one envelope word, forms key-scaled rates and looks up the tables.
// ----------------------------------------------------------------------------
module fmvs_op_decode
    import fmvs_pkg::*;
(
    input  logic                carrier,
    input  logic                key_pressed,
    input  logic [3:0]          frate,
    input  logic [ENV_BITS-1:0] envelope,
    output op_info_t            info
);

    logic [3:0] ar;
    logic [3:0] dr;
    logic [3:0] sl;
    logic [3:0] rr;
    logic [3:0] ksn;

    assign ar  = envelope[3:0];
    assign dr  = envelope[7:4];
    assign sl  = envelope[11:8];
    assign rr  = envelope[15:12];
    assign ksn = envelope[17] ? frate : {2'b00, frate[3:2]};

    always_comb
    begin
        info.eval     = carrier && (ar != 4'd0);
        info.never    = (rr == 4'd0) || ((dr == 4'd0) && (sl != 4'd0))
                        || (envelope[16] && key_pressed);
        if (dr == 4'd0)
        begin
            info.lvl = 5'd0;
        end
        else if (sl == 4'd15)
        begin
            info.lvl = 5'd24;
        end
        else
        begin
            info.lvl = {1'b0, sl};
        end
        info.atk      = atk_lookup(scaled_rate(ar, ksn));
        info.dec_step = rel_lookup(scaled_rate(dr, ksn));
        info.rel_step = rel_lookup(scaled_rate(rr, ksn));
    end

endmodule

@@ design/fmvs_op_time.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FM voice silence estimator operator timing
// Three register stages: multiply, sum and compare, saturating add.
// ----------------------------------------------------------------------------
module fmvs_op_time
    import fmvs_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  op_info_t             info,
    input  logic                 key_pressed,
    input  logic [TIME_BITS-1:0] time_now,
    input  logic [TIME_BITS-1:0] key_on_time,
    output logic                 eval,
    output logic                 never,
    output logic [TIME_BITS-1:0] op_time
);

    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    logic                 eval1_reg;
    logic                 never1_reg;
    logic                 key1_reg;
    logic [DUR_BITS-1:0]  atk1_reg;
    logic [DUR_BITS-1:0]  dec1_reg;
    logic [DUR_BITS-1:0]  rsus1_reg;
    logic [DUR_BITS-1:0]  rful1_reg;
    logic [TIME_BITS-1:0] now1_reg;
    logic [TIME_BITS-1:0] on1_reg;

    logic                 eval2_reg;
    logic                 never2_reg;
    logic [DUR_BITS+1:0]  add2_reg;
    logic [TIME_BITS-1:0] now2_reg;

    logic                 eval3_reg;
    logic                 never3_reg;
    logic [TIME_BITS-1:0] time3_reg;

    logic [TIME_BITS-1:0] elapsed;
    logic [DUR_BITS:0]    ad_sum;
    logic                 early;
    logic [DUR_BITS+1:0]  add2_next;
    logic [TIME_BITS:0]   sum3;

    assign elapsed = now1_reg - on1_reg;
    assign ad_sum  = {1'b0, atk1_reg} + {1'b0, dec1_reg};
    assign early   = (now1_reg < on1_reg)
                     || (elapsed < {{(TIME_BITS-DUR_BITS-1){1'b0}}, ad_sum});

    always_comb
    begin
        if (key1_reg)
        begin
            add2_next = {2'b00, atk1_reg} + {2'b00, dec1_reg} + {2'b00, rsus1_reg};
        end
        else if (early)
        begin
            add2_next = {2'b00, rful1_reg};
        end
        else
        begin
            add2_next = {2'b00, rsus1_reg};
        end
    end

    assign sum3 = {1'b0, now2_reg}
                  + {{(TIME_BITS-DUR_BITS-1){1'b0}}, add2_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eval1_reg <= 1'b0;
            eval2_reg <= 1'b0;
            eval3_reg <= 1'b0;
        end
        else
        begin
            eval1_reg <= in_valid && info.eval;
            eval2_reg <= eval1_reg;
            eval3_reg <= eval2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        never1_reg <= info.never;
        key1_reg   <= key_pressed;
        atk1_reg   <= {{(DUR_BITS-TAB_BITS){1'b0}}, info.atk};
        dec1_reg   <= {{(DUR_BITS-TAB_BITS){1'b0}}, info.dec_step}
                      * {{(DUR_BITS-5){1'b0}}, info.lvl};
        rsus1_reg  <= {{(DUR_BITS-TAB_BITS){1'b0}}, info.rel_step}
                      * {{(DUR_BITS-5){1'b0}}, 5'd24 - info.lvl};
        rful1_reg  <= {{(DUR_BITS-TAB_BITS){1'b0}}, info.rel_step}
                      * {{(DUR_BITS-5){1'b0}}, 5'd24};
        now1_reg   <= time_now;
        on1_reg    <= key_on_time;
        never2_reg <= never1_reg;
        add2_reg   <= add2_next;
        now2_reg   <= now1_reg;
        never3_reg <= never2_reg;
        time3_reg  <= sum3[TIME_BITS] ? TIME_MAX : sum3[TIME_BITS-1:0];
    end

    assign eval    = eval3_reg;
    assign never   = never3_reg;
    assign op_time = time3_reg;

endmodule

@@ design/fm_voice_silence_time_estimator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FM voice silence-time estimator
// Estimates when a 2- or 4-operator FM voice falls silent, in microseconds.
//
// An item is transferred at a clock edge with start high; busy is always low,
// so an item may enter every cycle. Carriers are chosen by the connection,
// each carrier runs through a three-stage timing pipe, and a final stage
// merges the carriers. The result is registered by that final stage and appears
// on silent_time and outcome for one cycle, marked by done.
// Throughput is one item per cycle, set by the fully pipelined carrier paths.
// The receiver cannot stall, so results never wait.
// The key-scale select register is written through cfg_valid and cfg_ready;
// it takes effect for items transferred after the write.
// Reset clears the key-scale select and all valid bits; no item is in flight
// after it.
// ----------------------------------------------------------------------------
module fm_voice_silence_time_estimator_unit
    import fmvs_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 key_pressed,
    input  logic                 four_operator,
    input  logic [9:0]           freq_number,
    input  logic [2:0]           freq_octave,
    input  logic [1:0]           connection_mode,
    input  logic [ENV_BITS-1:0]  envelope_op0,
    input  logic [ENV_BITS-1:0]  envelope_op1,
    input  logic [ENV_BITS-1:0]  envelope_op2,
    input  logic [ENV_BITS-1:0]  envelope_op3,
    input  logic [TIME_BITS-1:0] time_now,
    input  logic [TIME_BITS-1:0] key_on_time,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data,
    output logic                 done,
    output logic [TIME_BITS-1:0] silent_time,
    output logic [1:0]           outcome
);

    logic                 ksn_src_reg;
    logic [3:0]           carriers;
    logic [3:0]           frate;
    logic [ENV_BITS-1:0]  env [NUM_OPS];
    op_info_t             info [NUM_OPS];
    logic [NUM_OPS-1:0]   op_eval;
    logic [NUM_OPS-1:0]   op_never;
    logic [TIME_BITS-1:0] op_time [NUM_OPS];
    logic [2:0]           vld_reg;
    logic                 done_reg;
    logic [TIME_BITS-1:0] silent_time_reg;
    logic [1:0]           outcome_reg;
    logic [TIME_BITS-1:0] latest;
    logic [1:0]           outcome_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign frate     = {freq_octave,
                        ksn_src_reg ? freq_number[8] : freq_number[9]};
    assign env[0] = envelope_op0;
    assign env[1] = envelope_op1;
    assign env[2] = envelope_op2;
    assign env[3] = envelope_op3;

    always_comb
    begin
        if (four_operator)
        begin
            case (connection_mode)
                2'd0:    carriers = 4'b1000;
                2'd1:    carriers = 4'b1010;
                2'd2:    carriers = 4'b1001;
                default: carriers = 4'b1011;
            endcase
        end
        else
        begin
            carriers = {2'b00, 1'b1, connection_mode[0]};
        end
    end

    for (genvar g = 0; g < NUM_OPS; g++)
    begin : g_op
        fmvs_op_decode u_decode (
            .carrier     (carriers[g]),
            .key_pressed (key_pressed),
            .frate       (frate),
            .envelope    (env[g]),
            .info        (info[g])
        );

        fmvs_op_time #(.TIME_BITS(TIME_BITS)) u_time (
            .clk         (clk),
            .rst_n       (rst_n),
            .in_valid    (start),
            .info        (info[g]),
            .key_pressed (key_pressed),
            .time_now    (time_now),
            .key_on_time (key_on_time),
            .eval        (op_eval[g]),
            .never       (op_never[g]),
            .op_time     (op_time[g])
        );
    end

    always_comb
    begin
        latest = '0;
        for (int i = 0; i < NUM_OPS; i++)
        begin
            if (op_eval[i] && (op_time[i] > latest))
            begin
                latest = op_time[i];
            end
        end
        if ((op_eval & op_never) != '0)
        begin
            outcome_next = OUTCOME_NEVER;
        end
        else if (op_eval == '0)
        begin
            outcome_next = OUTCOME_SILENT;
        end
        else
        begin
            outcome_next = OUTCOME_TIME;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ksn_src_reg <= 1'b0;
            vld_reg     <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                ksn_src_reg <= cfg_data;
            end
            vld_reg  <= {vld_reg[1:0], start};
            done_reg <= vld_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        outcome_reg     <= outcome_next;
        silent_time_reg <= (outcome_next == OUTCOME_TIME) ? latest : '0;
    end

    assign done        = done_reg;
    assign silent_time = silent_time_reg;
    assign outcome     = outcome_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (op_eval != '0) |-> vld_reg[2])
        else $error("carrier result without an item in flight");
    assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##4 done)
        else $error("item did not complete in four cycles");
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (outcome != OUTCOME_UNUSED))
        else $error("reserved outcome code");
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (outcome != OUTCOME_TIME)) |-> (silent_time == '0))
        else $error("time given with no time outcome");

endmodule
